// ----- hw/rtl/sact_pkg.sv -----
// Package for the set-associative cache tag model: payload types and constants.
// No dependencies; used by all modules of the block.
package sact_pkg;
	localparam int BLOCK_SHIFT = 6;
	localparam int TAG_W = 64 - BLOCK_SHIFT;
	localparam int CFG_W = 4;

	localparam logic [1:0] REG_FIFO_MODE   = 2'd0;
	localparam logic [1:0] REG_WRITE_BACK  = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;
	localparam logic [1:0] REG_SET_BITS    = 2'd3;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [63:0] address;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic        memory_read;
		logic        memory_write;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] read_total;
		logic [31:0] write_total;
	} out_item_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic update;
	} sact_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic clearing;
	} sact_sts_t;
endpackage

// ----- hw/rtl/sact_ctrl.sv -----
// Controller of the cache tag model: sequences read, compare/update and output.
// Depends on sact_pkg.
module sact_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sact_pkg::sact_sts_t sts,
	output sact_pkg::sact_cmd_t cmd
);
	import sact_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;
	logic       free;

	// The output register is free when empty or being drained this cycle.
	assign free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE) && !sts.clearing;
	assign cmd.load = in_valid && in_ready;
	assign cmd.update = (state_q == ST_LOOK) && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_LOOK;
				ST_LOOK: if (free) state_q <= ST_OUT;
				ST_OUT: begin
					out_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> !in_ready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

	property p_update_after_load;
		@(posedge clk) disable iff (!arst_n) cmd.load |=> (state_q == ST_LOOK);
	endproperty
	a_update_after_load: assert property (p_update_after_load) else $error("bad sequence");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n) (out_valid && !out_ready) |=> out_valid;
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result dropped");
endmodule

// ----- hw/rtl/sact_dp.sv -----
// Datapath of the cache tag model: tag memory, marks, compare, reorder, counters.
// Depends on sact_pkg.
module sact_dp #(
	parameter int MAX_WAYS = 8,
	parameter int MAX_SETS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [3:0]           cfg_data,
	input  sact_pkg::in_item_t   in_item,
	input  sact_pkg::sact_cmd_t  cmd,
	output sact_pkg::sact_sts_t  sts,
	output sact_pkg::out_item_t  out_item
);
	import sact_pkg::*;

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W = $clog2(MAX_SETS + 1);

	typedef logic [TAG_W-1:0] tag_t;
	typedef tag_t [MAX_WAYS-1:0] row_t;
	typedef logic [MAX_WAYS-1:0] mark_t;

	row_t  tag_mem [MAX_SETS];
	mark_t val_mem [MAX_SETS];
	mark_t dty_mem [MAX_SETS];

	logic       fifo_q, wb_q;
	logic [3:0] ways_q, sbits_q;
	logic [CNT_W-1:0] clr_q;

	row_t  row_s1;
	mark_t val_s1, dty_s1;
	tag_t  blk_s1;
	logic  wr_s1;
	logic [SET_W-1:0] set_s1;
	logic [31:0] hit_q, miss_q, rd_q, wrc_q;
	logic res_hit_q, res_mrd_q, res_mw_q;

	tag_t  blk;
	logic [63:0] mask;
	logic [SET_W-1:0] set_idx;

	assign blk = in_item.address[63:BLOCK_SHIFT];
	assign mask = (64'd1 << sbits_q) - 64'd1;
	always_comb begin
		logic [63:0] m;
		m = {{BLOCK_SHIFT{1'b0}}, blk} & mask;
		set_idx = m[SET_W-1:0];
		if (MAX_SETS == 1) set_idx = '0;
	end
	assign sts.clearing = (clr_q != CNT_W'(MAX_SETS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_q <= 1'b0;
			wb_q <= 1'b0;
			ways_q <= 4'd1;
			sbits_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIFO_MODE:   fifo_q <= cfg_data[0];
				REG_WRITE_BACK:  wb_q <= cfg_data[0];
				REG_WAYS_IN_USE: ways_q <= cfg_data;
				REG_SET_BITS:    sbits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Compare and reorder.
	logic [WAY_W:0] ways;
	logic hit;
	logic [WAY_W-1:0] pos;
	logic mw;
	row_t  nrow;
	mark_t nval, ndty;
	always_comb begin
		logic [WAY_W:0] last;
		logic d;
		ways = (ways_q == 4'd0) ? (WAY_W+1)'(1)
			: ((int'(ways_q) > MAX_WAYS) ? (WAY_W+1)'(MAX_WAYS) : (WAY_W+1)'(ways_q));
		hit = 1'b0;
		pos = '0;
		for (int p = MAX_WAYS - 1; p >= 0; p--) begin
			if ((WAY_W+1)'(p) < ways && val_s1[p] && row_s1[p] == blk_s1) begin
				hit = 1'b1;
				pos = WAY_W'(p);
			end
		end
		last = hit ? {1'b0, pos} : ways - (WAY_W+1)'(1);
		d = hit ? dty_s1[pos] : (wb_q && wr_s1);
		mw = (!wb_q && wr_s1) ||
			(!hit && wb_q && val_s1[last[WAY_W-1:0]] && dty_s1[last[WAY_W-1:0]]);
		nrow = row_s1;
		nval = val_s1;
		ndty = dty_s1;
		if (!hit || !fifo_q) begin
			for (int p = 1; p < MAX_WAYS; p++) begin
				if ((WAY_W+1)'(p) <= last) begin
					nrow[p] = row_s1[p-1];
					nval[p] = val_s1[p-1];
					ndty[p] = dty_s1[p-1];
				end
			end
			nrow[0] = blk_s1;
			nval[0] = 1'b1;
			ndty[0] = d;
			if (hit && wb_q && wr_s1) ndty[0] = 1'b1;
		end else if (wb_q && wr_s1) begin
			ndty[pos] = 1'b1;
		end
	end

	// Tag memory: one row per set, read at load, written at update.
	always_ff @(posedge clk) begin
		if (cmd.load) row_s1 <= tag_mem[set_idx];
		if (cmd.update) tag_mem[set_s1] <= nrow;
		if (cmd.load) begin
			blk_s1 <= blk;
			wr_s1 <= (in_item.opcode == OP_WRITE);
			set_s1 <= set_idx;
		end
	end

	// Mark memories, swept to zero after reset.
	always_ff @(posedge clk) begin
		if (sts.clearing) begin
			val_mem[clr_q[SET_W-1:0]] <= '0;
			dty_mem[clr_q[SET_W-1:0]] <= '0;
		end else if (cmd.update) begin
			val_mem[set_s1] <= nval;
			dty_mem[set_s1] <= ndty;
		end
		if (cmd.load) begin
			val_s1 <= val_mem[set_idx];
			dty_s1 <= dty_mem[set_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			hit_q <= '0;
			miss_q <= '0;
			rd_q <= '0;
			wrc_q <= '0;
		end else begin
			if (sts.clearing) clr_q <= clr_q + CNT_W'(1);
			if (cmd.update) begin
				if (hit) hit_q <= hit_q + 32'd1;
				else begin
					miss_q <= miss_q + 32'd1;
					rd_q <= rd_q + 32'd1;
				end
				if (mw) wrc_q <= wrc_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_hit_q <= hit;
			res_mrd_q <= !hit;
			res_mw_q <= mw;
		end
	end
	assign out_item.hit = res_hit_q;
	assign out_item.memory_read = res_mrd_q;
	assign out_item.memory_write = res_mw_q;
	assign out_item.hit_total = hit_q;
	assign out_item.miss_total = miss_q;
	assign out_item.read_total = rd_q;
	assign out_item.write_total = wrc_q;

	property p_count_step;
		@(posedge clk) disable iff (!arst_n)
			cmd.update |=> (hit_q + miss_q == $past(hit_q + miss_q) + 32'd1);
	endproperty
	a_count_step: assert property (p_count_step) else $error("counter step");

	property p_no_load_clear;
		@(posedge clk) disable iff (!arst_n) sts.clearing |-> !cmd.load;
	endproperty
	a_no_load_clear: assert property (p_no_load_clear) else $error("load during clear");

	property p_front_valid;
		@(posedge clk) disable iff (!arst_n) cmd.update && !hit |-> nval[0];
	endproperty
	a_front_valid: assert property (p_front_valid) else $error("front not valid");
endmodule

// ----- hw/rtl/set_assoc_cache_tag_model_unit.sv -----
// Top level of the set-associative cache tag model.
// Depends on sact_pkg, sact_ctrl and sact_dp.
//
// One access (read or write with a 64-bit byte address) is taken at a time, and
// each yields one result with hit, memory read and memory write flags plus the
// four running counters. The set's tag row and marks are read from synchronous
// memory; once the output register is free, the ways are compared, the set is
// written back reordered and the result register loaded; then out_valid rises.
// After reset a clearing pass zeroes the valid and dirty marks, one set a
// cycle, before the first item is taken. The user must write configuration
// (cfg_we, cfg_index, cfg_data) only while idle; the block does not enforce it.
module set_assoc_cache_tag_model_unit #(
	parameter int MAX_WAYS = 8,
	parameter int MAX_SETS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [3:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  sact_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sact_pkg::out_item_t out_data
);
	import sact_pkg::*;

	sact_cmd_t cmd;
	sact_sts_t sts;

	sact_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	sact_dp #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_item(in_data), .cmd(cmd), .sts(sts),
		.out_item(out_data)
	);
endmodule
